// ===== rtl/bale_pkg.sv =====
package bale_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOCATE = 2'd2;
    localparam logic [1:0] KIND_SORTED = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [31:0]  value;
        logic [6:0]          position;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_index;
        logic [6:0] count_after;
    } t_resp;

endpackage

// ===== rtl/bounded_array_list_engine_core.sv =====
// Channel | Direction | Handshake              | Beat
// request | in        | i_in_valid / o_in_ready | t_req  (kind, value, position)
// result  | out       | o_out_valid / i_out_ready | t_resp (status, found_index, count_after)
//
// One request at a time; o_in_ready is high only while the sequencer is idle.
// A rejected request goes straight to the result state; its beat is registered once the output register is free.
// The longest walk is a missed locate in a full list.
// Reset (synchronous, active low) empties the list; the entry memory is not cleared.
// A stalled result holds the output register; the next request then waits in the result state.
module bounded_array_list_engine_core
    import bale_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_req  i_in_data,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_resp o_out_data
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_LOC,
        S_SORT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_ptr;
    logic [AW-1:0]       r_last;
    logic                r_up;
    logic                r_more;
    logic                r_rv;
    logic [AW-1:0]       r_ra;
    logic [AW-1:0]       r_pos;
    logic signed [31:0]  r_val;
    logic [1:0]          r_status;
    logic [AW-1:0]       r_idx;
    logic                r_out_valid;
    t_resp               r_out;

    logic signed [31:0]  mem [CAPACITY];
    logic signed [31:0]  r_rd_data;

    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic signed [31:0]  wr_data;
    logic                fin;
    logic                hit;
    logic                gt;
    logic                eq;
    logic [AW-1:0]       ra_inc;
    logic [AW-1:0]       ra_dec;
    logic [CMPW-1:0]     c_ext;
    logic [CMPW-1:0]     c_dec;
    logic [CMPW-1:0]     pos_ext;
    logic [CMPW-1:0]     pos_inc;
    logic [CMPW-1:0]     idx_ext;
    logic                full;
    logic                accept;

    assign c_ext   = CMPW'(r_count);
    assign c_dec   = c_ext - CMPW'(1);
    assign pos_ext = CMPW'(i_in_data.position);
    assign pos_inc = pos_ext + CMPW'(1);
    assign idx_ext = CMPW'(r_idx);
    assign full    = (c_ext == CMPW'(CAPACITY));
    assign ra_inc  = r_ra + AW'(1);
    assign ra_dec  = r_ra - AW'(1);
    assign accept  = i_in_valid && (r_state == S_IDLE);

    // The compare logic (gt for a sorted insert, eq for a locate): the entry read last cycle against the request value.
    assign gt = (r_rd_data > r_val);
    assign eq = (r_rd_data == r_val);

    always_comb begin
        fin     = 1'b0;
        hit     = 1'b0;
        wr_en   = 1'b0;
        wr_addr = ra_inc;
        wr_data = r_rd_data;
        case (r_state)
            S_INS: begin
                if (r_rv) begin
                    wr_en = 1'b1;
                end else if (!r_more) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_val;
                    fin     = 1'b1;
                end
            end
            S_DEL: begin
                if (r_rv) begin
                    wr_en   = 1'b1;
                    wr_addr = ra_dec;
                end else if (!r_more) begin
                    fin = 1'b1;
                end
            end
            S_LOC: begin
                if (r_rv && eq) begin
                    fin = 1'b1;
                    hit = 1'b1;
                end else if (!r_more && !r_rv) begin
                    fin = 1'b1;
                end
            end
            S_SORT: begin
                if (r_rv) begin
                    wr_en = 1'b1;
                    if (!gt) begin
                        wr_data = r_val;
                        fin     = 1'b1;
                    end
                end else if (!r_more) begin
                    // Every entry is greater, so the value lands at the head.
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = r_val;
                    fin     = 1'b1;
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
        rd_en = r_more && !fin;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_more      <= 1'b0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rv <= rd_en;
            r_ra <= r_ptr;
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (rd_en) begin
                if (r_ptr == r_last) begin
                    r_more <= 1'b0;
                end else if (r_up) begin
                    r_ptr <= r_ptr + AW'(1);
                end else begin
                    r_ptr <= r_ptr - AW'(1);
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_val    <= i_in_data.value;
                        r_pos    <= pos_ext[AW-1:0];
                        r_status <= ST_DONE;
                        r_idx    <= '0;
                        case (i_in_data.kind)
                            KIND_INSERT: begin
                                r_ptr  <= c_dec[AW-1:0];
                                r_last <= pos_ext[AW-1:0];
                                r_up   <= 1'b0;
                                r_more <= (pos_ext < c_ext);
                                if (pos_ext > c_ext) begin
                                    r_status <= ST_BAD_POS;
                                    r_state  <= S_DONE;
                                end else if (full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                    r_more   <= 1'b0;
                                end else begin
                                    r_state <= S_INS;
                                end
                            end
                            KIND_DELETE: begin
                                r_ptr  <= pos_inc[AW-1:0];
                                r_last <= c_dec[AW-1:0];
                                r_up   <= 1'b1;
                                r_more <= (pos_inc < c_ext);
                                if (pos_ext >= c_ext) begin
                                    r_status <= ST_BAD_POS;
                                    r_state  <= S_DONE;
                                    r_more   <= 1'b0;
                                end else begin
                                    r_state <= S_DEL;
                                end
                            end
                            KIND_LOCATE: begin
                                r_ptr   <= '0;
                                r_last  <= c_dec[AW-1:0];
                                r_up    <= 1'b1;
                                r_more  <= (c_ext != '0);
                                r_state <= S_LOC;
                            end
                            default: begin
                                r_ptr  <= c_dec[AW-1:0];
                                r_last <= '0;
                                r_up   <= 1'b0;
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                    r_more   <= 1'b0;
                                end else begin
                                    r_more  <= (c_ext != '0);
                                    r_state <= S_SORT;
                                end
                            end
                        endcase
                    end
                end
                S_INS, S_SORT: begin
                    if (fin) begin
                        r_more  <= 1'b0;
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DEL: begin
                    if (fin) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_LOC: begin
                    if (fin) begin
                        r_more  <= 1'b0;
                        r_state <= S_DONE;
                        if (hit) begin
                            r_idx <= r_ra;
                        end else begin
                            r_status <= ST_MISSING;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid       <= 1'b1;
                        r_out.status      <= r_status;
                        r_out.found_index <= idx_ext[5:0];
                        r_out.count_after <= c_ext[6:0];
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ext <= CMPW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CMPW'(wr_addr) <= c_ext))
        else $error("entry write beyond the end of the list");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |=> $stable(r_count))
        else $error("entry count changed outside a list update");

    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rv && !r_more)
        else $error("memory walk still running while idle");

endmodule
